// ===== src/rlh_pkg.sv =====
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared constants and types of the RGB/lightness histogram core.
// ----------------------------------------------------------------------------
package rlh_pkg;

   localparam int COUNT_BITS    = 24;
   localparam int FRACTION_BITS = 16;
   localparam int BINS          = 256;
   localparam int CHANNELS      = 4;

   localparam int PIXEL_BITS  = 8;
   localparam int ACTION_BITS = 2;
   localparam int CHAN_BITS   = $clog2(CHANNELS);
   localparam int BIN_BITS    = $clog2(BINS);

   localparam int FRAC_OUT_BITS = FRACTION_BITS + 1;
   localparam int QUOT_BITS     = COUNT_BITS + FRACTION_BITS;
   localparam int STEP_BITS     = $clog2(QUOT_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [QUOT_BITS-1:0]  FRAC_ONE   = QUOT_BITS'(1) << FRACTION_BITS;
   localparam logic [BIN_BITS-1:0]   SWEEP_LAST = BIN_BITS'(BINS - 1);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ACCUM = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DIV
   } state_type;

endpackage

// ===== src/rlh_if.sv =====
// ----------------------------------------------------------------------------
// rlh_req_if / rlh_rsp_if
// Valid/ready channels of the histogram core: request items and read results.
// ----------------------------------------------------------------------------
interface rlh_req_if import rlh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [PIXEL_BITS-1:0]  red;
   logic [PIXEL_BITS-1:0]  green;
   logic [PIXEL_BITS-1:0]  blue;
   logic [CHAN_BITS-1:0]   channel;
   logic [BIN_BITS-1:0]    bin;

   modport source (output valid, action, red, green, blue, channel, bin, input ready);
   modport sink   (input valid, action, red, green, blue, channel, bin, output ready);
endinterface

interface rlh_rsp_if import rlh_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COUNT_BITS-1:0]    count;
   logic [FRAC_OUT_BITS-1:0] fraction;
   logic                     no_pixels;

   modport source (output valid, count, fraction, no_pixels, input ready);
   modport sink   (input valid, count, fraction, no_pixels, output ready);
endinterface

// ===== src/rlh_ram.sv =====
// ----------------------------------------------------------------------------
// rlh_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rlh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rlh_div.sv =====
// ----------------------------------------------------------------------------
// rlh_div
// Bin fraction unit: (count << FRACTION_BITS) / total, restoring division,
// one quotient bit per cycle, clamped to one. A zero total finishes at once.
// ----------------------------------------------------------------------------
module rlh_div import rlh_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [COUNT_BITS-1:0]    count_in,
   input  logic [COUNT_BITS-1:0]    total_in,
   output logic                     done,
   output logic [FRAC_OUT_BITS-1:0] fraction,
   output logic                     no_pixels
);

   logic [STEP_BITS-1:0]  steps_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [QUOT_BITS-1:0]  quot_ff;
   logic [COUNT_BITS-1:0] divisor_ff;
   logic                  empty_ff;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  take;
   logic                  total_zero;
   logic [QUOT_BITS-1:0]  clamped;

   assign total_zero = (total_in == '0);
   assign trial      = {rem_ff, quot_ff[QUOT_BITS-1]};
   assign diff       = trial - {1'b0, divisor_ff};
   assign take       = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (start) begin
         steps_ff <= total_zero ? '0 : STEP_BITS'(QUOT_BITS);
      end else if (steps_ff != '0) begin
         steps_ff <= steps_ff - STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quot_ff    <= total_zero ? '0 : {count_in, FRACTION_BITS'(0)};
         divisor_ff <= total_in;
         empty_ff   <= total_zero;
      end else if (steps_ff != '0) begin
         rem_ff  <= take ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quot_ff <= {quot_ff[QUOT_BITS-2:0], take};
      end
   end

   assign clamped   = (quot_ff > FRAC_ONE) ? FRAC_ONE : quot_ff;
   assign done      = (steps_ff == '0);
   assign fraction  = clamped[FRAC_OUT_BITS-1:0];
   assign no_pixels = empty_ff;

endmodule

// ===== src/rgb_lightness_histogram_core.sv =====
// ----------------------------------------------------------------------------
// rgb_lightness_histogram_core
// Four 256-bin histograms (lightness, red, green, blue) of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Items arrive on req_chan (valid/ready). An accumulate item bumps one bin in
// each of the four channel banks and the pixel total; a read item returns one
// bin's count and count/total as 1.16 fixed point on rsp_chan; a clear item
// zeroes all bins and the total. Action 3 is ignored.
// Accumulate items are taken one per cycle while req_chan.ready is high: each
// bank is a 256-entry RAM with a registered read, and the write-back of the
// previous item is forwarded when it hits the same bin. Clear and accumulate
// give no result. A read item looks up the bin in all banks, then runs the
// bit-serial divider (one quotient bit per cycle); req_chan.ready is low until
// the result is loaded. A zero total skips the divide and sets no_pixels.
// The result sits in an output register; a stalled rsp_chan does not block
// accumulate or clear items, only the completion of the next read.
// At reset and after each clear item all 256 bins are swept to zero, one bin
// per cycle in all four banks; req_chan.ready is low meanwhile.
// ----------------------------------------------------------------------------
module rgb_lightness_histogram_core import rlh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rlh_req_if.sink   req_chan,
   rlh_rsp_if.source rsp_chan
);

   state_type state_ff;
   state_type state_in;

   logic [BIN_BITS-1:0]   sweep_ff;
   logic [COUNT_BITS-1:0] pixel_total_ff;

   logic req_fire;
   logic acc_go;
   logic read_go;
   logic clear_go;

   // stage 1: bank read data valid
   logic                 s1_acc_ff;
   logic                 s1_read_ff;
   logic [CHAN_BITS-1:0] s1_chan_ff;
   logic [BIN_BITS-1:0]  s1_addr_ff [CHANNELS];

   logic [BIN_BITS-1:0]   bank_raddr [CHANNELS];
   logic [COUNT_BITS-1:0] bank_q     [CHANNELS];
   logic [COUNT_BITS-1:0] bank_cur   [CHANNELS];
   logic                  bank_we    [CHANNELS];
   logic [BIN_BITS-1:0]   bank_waddr [CHANNELS];
   logic [COUNT_BITS-1:0] bank_wdata [CHANNELS];

   logic                  fwd_valid_ff [CHANNELS];
   logic [BIN_BITS-1:0]   fwd_addr_ff  [CHANNELS];
   logic [COUNT_BITS-1:0] fwd_data_ff  [CHANNELS];

   logic [PIXEL_BITS-1:0] pix_max;
   logic [PIXEL_BITS-1:0] pix_min;
   logic [PIXEL_BITS:0]   pix_sum;
   logic [PIXEL_BITS-1:0] lightness;

   logic                     div_start;
   logic                     div_done;
   logic [FRAC_OUT_BITS-1:0] div_fraction;
   logic                     div_no_pixels;
   logic [COUNT_BITS-1:0]    read_count_ff;

   logic                     rsp_load;
   logic                     rsp_valid_ff;
   logic [COUNT_BITS-1:0]    rsp_count_ff;
   logic [FRAC_OUT_BITS-1:0] rsp_fraction_ff;
   logic                     rsp_no_pixels_ff;

   // ---- request decode ----
   assign req_chan.ready = (state_ff == ST_RUN) && !s1_read_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      acc_go   = 1'b0;
      read_go  = 1'b0;
      clear_go = 1'b0;
      unique case (action_type'(req_chan.action))
         ACT_ACCUM: acc_go   = req_fire;
         ACT_READ:  read_go  = req_fire;
         ACT_CLEAR: clear_go = req_fire;
         default: ;
      endcase
   end

   // lightness = floor((max + min) / 2)
   always_comb begin
      pix_max = req_chan.red;
      pix_min = req_chan.red;
      if (req_chan.green > pix_max) pix_max = req_chan.green;
      if (req_chan.blue > pix_max)  pix_max = req_chan.blue;
      if (req_chan.green < pix_min) pix_min = req_chan.green;
      if (req_chan.blue < pix_min)  pix_min = req_chan.blue;
   end

   assign pix_sum   = {1'b0, pix_max} + {1'b0, pix_min};
   assign lightness = pix_sum[PIXEL_BITS:1];

   // a read item looks up the same bin in every bank
   always_comb begin
      if (req_chan.action == ACT_READ) begin
         bank_raddr[0] = req_chan.bin;
         bank_raddr[1] = req_chan.bin;
         bank_raddr[2] = req_chan.bin;
         bank_raddr[3] = req_chan.bin;
      end else begin
         bank_raddr[0] = lightness[BIN_BITS-1:0];
         bank_raddr[1] = req_chan.red[BIN_BITS-1:0];
         bank_raddr[2] = req_chan.green[BIN_BITS-1:0];
         bank_raddr[3] = req_chan.blue[BIN_BITS-1:0];
      end
   end

   // ---- stage 1 ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_acc_ff  <= 1'b0;
         s1_read_ff <= 1'b0;
      end else begin
         s1_acc_ff  <= acc_go;
         s1_read_ff <= read_go;
      end
   end

   always_ff @(posedge clock) begin
      s1_chan_ff <= req_chan.channel;
      for (int c = 0; c < CHANNELS; c++) begin
         s1_addr_ff[c] <= bank_raddr[c];
      end
   end

   // ---- banks ----
   for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
      // write of the previous cycle is not yet visible in the read data
      assign bank_cur[c] = (fwd_valid_ff[c] && (fwd_addr_ff[c] == s1_addr_ff[c]))
                           ? fwd_data_ff[c] : bank_q[c];

      always_comb begin
         if (state_ff == ST_CLEAR) begin
            bank_we[c]    = 1'b1;
            bank_waddr[c] = sweep_ff;
            bank_wdata[c] = '0;
         end else begin
            bank_we[c]    = s1_acc_ff;
            bank_waddr[c] = s1_addr_ff[c];
            bank_wdata[c] = (bank_cur[c] == COUNT_MAX) ? COUNT_MAX
                            : bank_cur[c] + COUNT_BITS'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fwd_valid_ff[c] <= 1'b0;
         end else begin
            fwd_valid_ff[c] <= bank_we[c];
         end
      end

      always_ff @(posedge clock) begin
         fwd_addr_ff[c] <= bank_waddr[c];
         fwd_data_ff[c] <= bank_wdata[c];
      end

      rlh_ram #(
         .WIDTH (COUNT_BITS),
         .DEPTH (BINS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[c]),
         .wr_addr (bank_waddr[c]),
         .wr_data (bank_wdata[c]),
         .rd_addr (bank_raddr[c]),
         .rd_data (bank_q[c])
      );
   end

   // ---- pixel total ----
   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         pixel_total_ff <= '0;
      end else if (acc_go && (pixel_total_ff != COUNT_MAX)) begin
         pixel_total_ff <= pixel_total_ff + COUNT_BITS'(1);
      end
   end

   // ---- control ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == SWEEP_LAST) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (clear_go) begin
               state_in = ST_CLEAR;
            end else if (s1_read_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_load = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (state_ff != ST_CLEAR)) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_ff + BIN_BITS'(1);
      end
   end

   // ---- fraction ----
   always_ff @(posedge clock) begin
      if (div_start) begin
         read_count_ff <= bank_cur[s1_chan_ff];
      end
   end

   rlh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .count_in  (bank_cur[s1_chan_ff]),
      .total_in  (pixel_total_ff),
      .done      (div_done),
      .fraction  (div_fraction),
      .no_pixels (div_no_pixels)
   );

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_count_ff     <= read_count_ff;
         rsp_fraction_ff  <= div_fraction;
         rsp_no_pixels_ff <= div_no_pixels;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.fraction  = rsp_fraction_ff;
   assign rsp_chan.no_pixels = rsp_no_pixels_ff;

endmodule
